### src/sitra_pkg.sv
// ----------------------------------------------------------------------------
// sitra_pkg: shared types and constants of the integer to ASCII converter
// Widths, radix codes, the queued item format and the character mapping.
// ----------------------------------------------------------------------------
package sitra_pkg;

    localparam int VALUE_BITS = 32;

    // Digit counts for the widest value in each radix.
    localparam int DEC_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int BIN_DIGITS = VALUE_BITS;

    localparam int DIGIT_BITS = 4 * DEC_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int BIT_W      = $clog2(VALUE_BITS);

    localparam int SH_BIN = DIGIT_BITS - BIN_DIGITS;
    localparam int SH_OCT = DIGIT_BITS - 3 * OCT_DIGITS;
    localparam int SH_HEX = DIGIT_BITS - 4 * HEX_DIGITS;

    localparam logic [2:0] MODE_DEC   = 3'd0;
    localparam logic [2:0] MODE_BIN   = 3'd1;
    localparam logic [2:0] MODE_OCT   = 3'd2;
    localparam logic [2:0] MODE_HEXU  = 3'd3;
    localparam logic [2:0] MODE_HEXL  = 3'd4;
    localparam logic [2:0] MODE_NONE  = 3'd5;
    localparam logic [2:0] MODE_RSV6  = 3'd6;
    localparam logic [2:0] MODE_RSV7  = 3'd7;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_UPPER = 8'h41;
    localparam logic [7:0] CHR_LOWER = 8'h61;

    typedef logic [VALUE_BITS-1:0] t_mag;
    typedef logic [DIGIT_BITS-1:0] t_digits;

    typedef struct packed {
        logic       neg;
        logic [2:0] radix;
        t_mag       mag;
    } t_job;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] base;
        if (d < 4'd10) begin
            digit_char = CHR_ZERO + {4'h0, d};
        end else begin
            base = lower ? CHR_LOWER : CHR_UPPER;
            digit_char = base + {4'h0, d} - 8'd10;
        end
    endfunction

    // One shift-and-add-3 step of the binary to BCD conversion.
    function automatic t_digits dabble(input t_digits bcd, input logic in_bit);
        t_digits adj;
        logic [3:0] dig;
        adj = bcd;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            dig = bcd[4*i +: 4];
            if (dig >= 4'd5) begin
                adj[4*i +: 4] = dig + 4'd3;
            end
        end
        dabble = {adj[DIGIT_BITS-2:0], in_bit};
    endfunction

endpackage

### src/sitra_if.sv
// ----------------------------------------------------------------------------
// sitra_if: item channels of the integer to ASCII converter
// Valid/ready channels for the input value and for the output characters.
// ----------------------------------------------------------------------------
interface sitra_in_if import sitra_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sitra_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

### src/signed_int_to_radix_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_ascii: signed integer to ASCII text converter
// Prints each signed input value as text in the configured radix.
// ----------------------------------------------------------------------------
// Usage: i_in carries one signed value per item; o_out returns the text one
// character per item, an optional minus sign, the digits most significant
// first and a final NUL item with last_char set. i_cfg_we writes the radix
// mode from i_cfg_data (0 decimal, 1 binary, 2 octal, 3 upper hex, 4 lower
// hex, other codes print only the NUL). i_cfg_we is to be used only while
// the block is idle; the block itself does not enforce this. An accepted
// value enters a two-entry queue; the generator pops it from the queue when
// the generator is idle. Decimal output first runs a shift-and-add-3
// conversion of one magnitude bit per cycle. The generator then sends the
// characters and drops leading zero digits without sending them. The queue
// takes new values while a character waits. A stalled receiver holds the
// current character. Reset empties the queue, returns the generator to idle
// and sets decimal mode.
// ----------------------------------------------------------------------------
module signed_int_to_radix_ascii import sitra_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    sitra_in_if.sink    i_in,
    sitra_out_if.source o_out
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    sitra_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    sitra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    sitra_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

### src/sitra_front.sv
// ----------------------------------------------------------------------------
// sitra_front: input side of the converter
// Holds the radix register, takes items and splits them into sign, magnitude
// and radix code for the queue.
// ----------------------------------------------------------------------------
module sitra_front import sitra_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_data,
    sitra_in_if.sink       i_in,
    input  logic           i_full,
    output logic           o_push,
    output t_job           o_job
);

    logic [2:0] r_mode;
    t_mag       w_raw;
    logic       w_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DEC;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    assign w_raw = t_mag'(i_in.value);
    assign w_neg = w_raw[VALUE_BITS-1];

    always_comb begin
        o_job.neg = w_neg;
        o_job.mag = w_neg ? (~w_raw + t_mag'(1)) : w_raw;
        unique case (r_mode) inside
            MODE_DEC:  o_job.radix = MODE_DEC;
            MODE_BIN:  o_job.radix = MODE_BIN;
            MODE_OCT:  o_job.radix = MODE_OCT;
            MODE_HEXU: o_job.radix = MODE_HEXU;
            MODE_HEXL: o_job.radix = MODE_HEXL;
            MODE_NONE, MODE_RSV6, MODE_RSV7: o_job.radix = MODE_NONE;
            default:   o_job.radix = MODE_NONE;
        endcase
    end

endmodule

### src/sitra_queue.sv
// ----------------------------------------------------------------------------
// sitra_queue: two-entry item queue
// Decouples the input side from the character generator.
// ----------------------------------------------------------------------------
module sitra_queue import sitra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full) |-> i_pop)
        else $error("Queue written while full.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("Queue read while empty.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop && !o_full) |=> !o_empty)
        else $error("Queue lost an item.");

endmodule

### src/sitra_back.sv
// ----------------------------------------------------------------------------
// sitra_back: character generator
// Converts a queued magnitude to digits; sends sign if negative, digits, NUL.
// ----------------------------------------------------------------------------
module sitra_back import sitra_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_job       i_job,
    output logic       o_pop,
    sitra_out_if.source o_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_DIG  = 3'd3;
    localparam logic [2:0] ST_NUL  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic             r_neg, n_neg;
    logic [2:0]       r_radix, n_radix;
    t_mag             r_mag, n_mag;
    t_digits          r_digits, n_digits;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic             r_started, n_started;

    logic [3:0] w_top;
    t_digits    w_shifted;
    logic       w_skip;
    logic       w_take;

    always_comb begin
        case (r_radix)
            MODE_BIN: begin
                w_top     = {3'b000, r_digits[DIGIT_BITS-1]};
                w_shifted = r_digits << 1;
            end
            MODE_OCT: begin
                w_top     = {1'b0, r_digits[DIGIT_BITS-1 -: 3]};
                w_shifted = r_digits << 3;
            end
            default: begin
                w_top     = r_digits[DIGIT_BITS-1 -: 4];
                w_shifted = r_digits << 4;
            end
        endcase
    end

    assign w_skip = (r_state == ST_DIG) && !r_started && (w_top == 4'd0)
                    && (r_cnt != CNT_W'(1));

    assign o_out.valid = (r_state == ST_SIGN) || (r_state == ST_NUL)
                         || ((r_state == ST_DIG) && !w_skip);
    assign o_out.last_char = (r_state == ST_NUL);
    assign w_take = o_out.valid && o_out.ready;
    assign o_pop  = (r_state == ST_IDLE) && !i_empty;

    always_comb begin
        case (r_state)
            ST_SIGN: o_out.text_char = CHR_MINUS;
            ST_DIG:  o_out.text_char = digit_char(w_top, r_radix == MODE_HEXL);
            default: o_out.text_char = CHR_NUL;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_neg     = r_neg;
        n_radix   = r_radix;
        n_mag     = r_mag;
        n_digits  = r_digits;
        n_cnt     = r_cnt;
        n_bit     = r_bit;
        n_started = r_started;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_neg     = i_job.neg;
                    n_radix   = i_job.radix;
                    n_mag     = i_job.mag;
                    n_started = 1'b0;
                    n_bit     = BIT_W'(VALUE_BITS - 1);
                    case (i_job.radix) inside
                        MODE_DEC: begin
                            n_digits = '0;
                            n_cnt    = CNT_W'(DEC_DIGITS);
                            n_state  = ST_CONV;
                        end
                        MODE_BIN: begin
                            n_digits = t_digits'(i_job.mag) << SH_BIN;
                            n_cnt    = CNT_W'(BIN_DIGITS);
                            n_state  = i_job.neg ? ST_SIGN : ST_DIG;
                        end
                        MODE_OCT: begin
                            n_digits = t_digits'(i_job.mag) << SH_OCT;
                            n_cnt    = CNT_W'(OCT_DIGITS);
                            n_state  = i_job.neg ? ST_SIGN : ST_DIG;
                        end
                        MODE_HEXU, MODE_HEXL: begin
                            n_digits = t_digits'(i_job.mag) << SH_HEX;
                            n_cnt    = CNT_W'(HEX_DIGITS);
                            n_state  = i_job.neg ? ST_SIGN : ST_DIG;
                        end
                        default: n_state = ST_NUL;
                    endcase
                end
            end
            ST_CONV: begin
                n_digits = dabble(r_digits, r_mag[VALUE_BITS-1]);
                n_mag    = r_mag << 1;
                n_bit    = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_state = r_neg ? ST_SIGN : ST_DIG;
                end
            end
            ST_SIGN: begin
                if (w_take) begin
                    n_state = ST_DIG;
                end
            end
            ST_DIG: begin
                if (w_skip || w_take) begin
                    n_digits = w_shifted;
                    n_cnt    = r_cnt - CNT_W'(1);
                end
                if (w_take) begin
                    n_started = 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_NUL;
                    end
                end
            end
            ST_NUL: begin
                if (w_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg     <= n_neg;
        r_radix   <= n_radix;
        r_mag     <= n_mag;
        r_digits  <= n_digits;
        r_cnt     <= n_cnt;
        r_bit     <= n_bit;
        r_started <= n_started;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIG) |-> (r_cnt != '0))
        else $error("Digit state entered with no digits left.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && o_out.last_char) |=> (r_state == ST_IDLE))
        else $error("Generator did not return to idle after the NUL item.");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state != ST_IDLE))
        else $error("Popped item was not started.");

endmodule
